FILE: hdl/imrh_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and widths for the image map region hit test.
// No dependencies; every other file of the block imports this package.
package imrh_pkg;

  localparam int unsigned COORD_W      = 16;
  localparam int unsigned TAG_W        = 16;
  localparam int unsigned KIND_W       = 3;
  localparam int unsigned OUTCOME_W    = 3;
  localparam int unsigned DIFF_W       = COORD_W + 1;
  localparam int unsigned PROD_W       = 2 * DIFF_W;
  localparam int unsigned DIST_W       = PROD_W;
  localparam int unsigned CFG_INDEX_W  = 1;
  localparam int unsigned CFG_DATA_W   = COORD_W;
  localparam int unsigned MAX_VERT_DEF = 128;

  typedef enum logic [KIND_W-1:0] {
    KIND_RECT    = 3'd0,
    KIND_CIRCLE  = 3'd1,
    KIND_POLYGON = 3'd2,
    KIND_DEFAULT = 3'd3,
    KIND_POINT   = 3'd4,
    KIND_MARKER  = 3'd5
  } region_kind_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_NONE    = 3'd0,
    OUT_HIT     = 3'd1,
    OUT_DEFAULT = 3'd2,
    OUT_NEAREST = 3'd3,
    OUT_FEW     = 3'd4,
    OUT_MANY    = 3'd5
  } outcome_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PROBE_X = 1'b0,
    REG_PROBE_Y = 1'b1
  } reg_index_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic [DIST_W-1:0]         dist_t;

  // Edge operands: straddle already folds in whether the edge is tested.
  typedef struct packed {
    logic  straddle;
    logic  up;
    logic  split;
    logic  right;
    diff_t ex;
    diff_t dy;
    diff_t ey;
    diff_t dx;
  } edge_op_t;

  typedef struct packed {
    logic  straddle;
    logic  up;
    logic  split;
    logic  right;
    prod_t p1;
    prod_t p2;
  } edge_prod_t;

  typedef struct packed {
    logic             live;
    logic             ends;
    logic             map_end;
    region_kind_t     kind;
    logic [TAG_W-1:0] tag;
    logic             err_many;
    logic             err_few;
    logic             rect_hit;
    edge_op_t         e1;
    edge_op_t         e2;
    diff_t            cdx;
    diff_t            cdy;
    diff_t            rdx;
    diff_t            rdy;
  } front_word_t;

  typedef struct packed {
    logic             live;
    logic             ends;
    logic             map_end;
    region_kind_t     kind;
    logic [TAG_W-1:0] tag;
    logic             err_many;
    logic             err_few;
    logic             rect_hit;
    edge_prod_t       e1;
    edge_prod_t       e2;
    dist_t            cdx2;
    dist_t            cdy2;
    dist_t            rdx2;
    dist_t            rdy2;
  } prod_word_t;

  typedef struct packed {
    logic             live;
    logic             ends;
    logic             map_end;
    region_kind_t     kind;
    logic [TAG_W-1:0] tag;
    logic             err_many;
    logic             err_few;
    logic             rect_hit;
    logic             cross1;
    logic             cross2;
    dist_t            dp;
    dist_t            dr;
  } sum_word_t;

endpackage

FILE: hdl/imrh_if.sv
`timescale 1ns / 1ps
// Valid/ready channels of the hit test: region vertex words in, result words out.
// Depends on imrh_pkg for field widths.
interface imrh_item_if;
  import imrh_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [KIND_W-1:0]          region_kind;
  logic signed [COORD_W-1:0]  vertex_x;
  logic signed [COORD_W-1:0]  vertex_y;
  logic [TAG_W-1:0]           target_tag;
  logic                       region_end;
  logic                       map_end;

  modport source (
    output valid, region_kind, vertex_x, vertex_y, target_tag, region_end, map_end,
    input  ready
  );
  modport sink (
    input  valid, region_kind, vertex_x, vertex_y, target_tag, region_end, map_end,
    output ready
  );
endinterface

interface imrh_result_if;
  import imrh_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OUTCOME_W-1:0] outcome;
  logic [TAG_W-1:0]     chosen_tag;

  modport source (output valid, outcome, chosen_tag, input ready);
  modport sink (input valid, outcome, chosen_tag, output ready);
endinterface

FILE: hdl/image_map_region_hit_test_unit.sv
`timescale 1ns / 1ps
// Image map region hit test: tests the probe point against a streamed list of regions.
// Channel item carries vertex words, one per cycle unless stalled; each region ends on
// a word with region_end, the map on a word with map_end (which also ends its region).
// Channel result carries one word per map: outcome and chosen_tag, taken from the
// first hit or error, else the last default or the nearest point region.
// Probe coordinates are written through cfg_write/cfg_index/cfg_data: index 0 sets
// probe_x, index 1 sets probe_y. The user must write them only while the block is
// idle; the block itself does not enforce this. Throughput: one vertex word per cycle
// unless stalled, set by the four-register pipeline (operand prep, products, sums and
// edge signs, decision), through which a map_end word passes to the result register.
// The result register holds a word until it is taken; vertex words keep flowing
// meanwhile, and only a second map_end word reaching the decision stage stalls the
// pipeline and drops item.ready.
// Reset (rst, synchronous) clears the probe to the origin, the region state, the
// current pick and the valid flag of the result register.
module image_map_region_hit_test_unit #(
  parameter int unsigned MAX_VERTICES = imrh_pkg::MAX_VERT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [imrh_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [imrh_pkg::CFG_DATA_W-1:0]  cfg_data,
  imrh_item_if.sink                        item,
  imrh_result_if.source                    result
);
  import imrh_pkg::*;

  logic        stall;
  logic        s1_valid;
  front_word_t s1_word;
  logic        s3_valid;
  sum_word_t   s3_word;

  imrh_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .stall     (stall),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .s1_valid  (s1_valid),
    .s1_word   (s1_word)
  );

  imrh_arith u_arith (
    .clk      (clk),
    .rst      (rst),
    .stall    (stall),
    .s1_valid (s1_valid),
    .s1_word  (s1_word),
    .s3_valid (s3_valid),
    .s3_word  (s3_word)
  );

  imrh_decide u_decide (
    .clk      (clk),
    .rst      (rst),
    .s3_valid (s3_valid),
    .s3_word  (s3_word),
    .stall    (stall),
    .result   (result)
  );

  assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.outcome == OUT_NONE || result.outcome == OUT_FEW ||
                     result.outcome == OUT_MANY) |-> result.chosen_tag == '0)
    else $error("error or empty outcome carries a nonzero tag");

  assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(s3_valid && s3_word.map_end))
    else $error("result word without a map end word in the decision stage");

  assert property (@(posedge clk) disable iff (rst)
    stall |=> s3_valid && s3_word.map_end)
    else $error("stalled decision stage lost its map end word");

endmodule

FILE: hdl/imrh_front.sv
`timescale 1ns / 1ps
// Input stage: probe registers, region vertex tracking and operand preparation.
// Depends on imrh_pkg and imrh_item_if.
module imrh_front #(
  parameter int unsigned MAX_VERTICES = imrh_pkg::MAX_VERT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                stall,
  input  logic                                cfg_write,
  input  logic [imrh_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [imrh_pkg::CFG_DATA_W-1:0]     cfg_data,
  imrh_item_if.sink                           item,
  output logic                                s1_valid,
  output imrh_pkg::front_word_t               s1_word
);
  import imrh_pkg::*;

  localparam int unsigned TALLY_W = $clog2(MAX_VERTICES + 2);
  localparam logic [TALLY_W-1:0] TALLY_MAX = TALLY_W'(MAX_VERTICES);

  coord_t             probe_x;
  coord_t             probe_y;
  coord_t             first_vx;
  coord_t             first_vy;
  coord_t             second_vx;
  coord_t             second_vy;
  coord_t             prior_vx;
  coord_t             prior_vy;
  logic [TALLY_W-1:0] tally;

  coord_t             first_vx_next;
  coord_t             first_vy_next;
  coord_t             second_vx_next;
  coord_t             second_vy_next;
  logic [TALLY_W-1:0] tally_next;
  logic [TALLY_W-1:0] need;
  logic               fire;
  logic               live;
  logic               ends;
  front_word_t        word_next;

  function automatic edge_op_t make_edge(input logic en, input coord_t x0, input coord_t y0,
                                         input coord_t x1, input coord_t y1,
                                         input coord_t px, input coord_t py);
    edge_op_t e;
    logic     a;
    logic     b;
    logic     c;
    logic     d;
    a          = (y0 >= py);
    b          = (y1 >= py);
    c          = (x0 >= px);
    d          = (x1 >= px);
    e.straddle = en && (a != b);
    e.up       = b;
    e.split    = (c != d);
    e.right    = c;
    e.ex       = diff_t'(x0) - diff_t'(px);
    e.dy       = diff_t'(y1) - diff_t'(y0);
    e.ey       = diff_t'(y0) - diff_t'(py);
    e.dx       = diff_t'(x1) - diff_t'(x0);
    return e;
  endfunction

  assign item.ready = !stall;
  assign fire       = item.valid && item.ready;
  assign live       = (item.region_kind <= KIND_POINT);
  assign ends       = item.region_end || item.map_end;

  always_comb begin
    first_vx_next  = (tally == '0) ? item.vertex_x : first_vx;
    first_vy_next  = (tally == '0) ? item.vertex_y : first_vy;
    second_vx_next = (tally == TALLY_W'(1)) ? item.vertex_x : second_vx;
    second_vy_next = (tally == TALLY_W'(1)) ? item.vertex_y : second_vy;
    tally_next     = (tally <= TALLY_MAX) ? tally + TALLY_W'(1) : tally;
  end

  always_comb begin
    case (item.region_kind) inside
      KIND_POLYGON:             need = TALLY_W'(3);
      KIND_RECT, KIND_CIRCLE:   need = TALLY_W'(2);
      default:                  need = TALLY_W'(1);
    endcase
  end

  always_comb begin
    word_next.live     = live;
    word_next.ends     = ends;
    word_next.map_end  = item.map_end;
    word_next.kind     = region_kind_t'(item.region_kind);
    word_next.tag      = item.target_tag;
    word_next.err_many = (tally_next > TALLY_MAX);
    word_next.err_few  = (tally_next < need);
    word_next.rect_hit = (((probe_x >= first_vx_next) && (probe_x <= second_vx_next)) ||
                          ((probe_x >= second_vx_next) && (probe_x <= first_vx_next))) &&
                         (((probe_y >= first_vy_next) && (probe_y <= second_vy_next)) ||
                          ((probe_y >= second_vy_next) && (probe_y <= first_vy_next)));
    word_next.e1       = make_edge(live && (tally != '0), prior_vx, prior_vy,
                                   item.vertex_x, item.vertex_y, probe_x, probe_y);
    word_next.e2       = make_edge(live && ends, item.vertex_x, item.vertex_y,
                                   first_vx_next, first_vy_next, probe_x, probe_y);
    word_next.cdx      = diff_t'(first_vx_next) - diff_t'(probe_x);
    word_next.cdy      = diff_t'(first_vy_next) - diff_t'(probe_y);
    word_next.rdx      = diff_t'(first_vx_next) - diff_t'(second_vx_next);
    word_next.rdy      = diff_t'(first_vy_next) - diff_t'(second_vy_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_x   <= '0;
      probe_y   <= '0;
      first_vx  <= '0;
      first_vy  <= '0;
      second_vx <= '0;
      second_vy <= '0;
      prior_vx  <= '0;
      prior_vy  <= '0;
      tally     <= '0;
      s1_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (reg_index_t'(cfg_index))
          REG_PROBE_X: probe_x <= coord_t'(cfg_data);
          REG_PROBE_Y: probe_y <= coord_t'(cfg_data);
        endcase
      end
      if (fire && live) begin
        first_vx  <= first_vx_next;
        first_vy  <= first_vy_next;
        second_vx <= second_vx_next;
        second_vy <= second_vy_next;
        prior_vx  <= item.vertex_x;
        prior_vy  <= item.vertex_y;
      end
      if (fire && ends) begin
        tally <= '0;
      end else if (fire && live) begin
        tally <= tally_next;
      end
      if (!stall) begin
        s1_valid <= fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s1_word <= word_next;
    end
  end

endmodule

FILE: hdl/imrh_arith.sv
`timescale 1ns / 1ps
// Product and sum stages: edge cross products, squared distances, edge crossings.
// Depends on imrh_pkg.
module imrh_arith (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  stall,
  input  logic                  s1_valid,
  input  imrh_pkg::front_word_t s1_word,
  output logic                  s3_valid,
  output imrh_pkg::sum_word_t   s3_word
);
  import imrh_pkg::*;

  localparam int unsigned LHS_W = PROD_W + 1;

  logic       s2_valid;
  prod_word_t s2_word;
  prod_word_t s2_next;
  sum_word_t  s3_next;

  function automatic edge_prod_t mul_edge(input edge_op_t e);
    edge_prod_t p;
    p.straddle = e.straddle;
    p.up       = e.up;
    p.split    = e.split;
    p.right    = e.right;
    p.p1       = PROD_W'(e.ex) * PROD_W'(e.dy);
    p.p2       = PROD_W'(e.ey) * PROD_W'(e.dx);
    return p;
  endfunction

  function automatic logic crosses(input edge_prod_t p);
    logic signed [LHS_W-1:0] lhs;
    logic                    res;
    lhs = LHS_W'(p.p1) - LHS_W'(p.p2);
    if (!p.straddle) begin
      res = 1'b0;
    end else if (!p.split) begin
      res = p.right;
    end else if (p.up) begin
      res = !lhs[LHS_W-1];
    end else begin
      res = lhs[LHS_W-1] || (lhs == '0);
    end
    return res;
  endfunction

  always_comb begin
    prod_t cx2;
    prod_t cy2;
    prod_t rx2;
    prod_t ry2;
    cx2               = PROD_W'(s1_word.cdx) * PROD_W'(s1_word.cdx);
    cy2               = PROD_W'(s1_word.cdy) * PROD_W'(s1_word.cdy);
    rx2               = PROD_W'(s1_word.rdx) * PROD_W'(s1_word.rdx);
    ry2               = PROD_W'(s1_word.rdy) * PROD_W'(s1_word.rdy);
    s2_next.live      = s1_word.live;
    s2_next.ends      = s1_word.ends;
    s2_next.map_end   = s1_word.map_end;
    s2_next.kind      = s1_word.kind;
    s2_next.tag       = s1_word.tag;
    s2_next.err_many  = s1_word.err_many;
    s2_next.err_few   = s1_word.err_few;
    s2_next.rect_hit  = s1_word.rect_hit;
    s2_next.e1        = mul_edge(s1_word.e1);
    s2_next.e2        = mul_edge(s1_word.e2);
    s2_next.cdx2      = $unsigned(cx2);
    s2_next.cdy2      = $unsigned(cy2);
    s2_next.rdx2      = $unsigned(rx2);
    s2_next.rdy2      = $unsigned(ry2);
  end

  always_comb begin
    s3_next.live     = s2_word.live;
    s3_next.ends     = s2_word.ends;
    s3_next.map_end  = s2_word.map_end;
    s3_next.kind     = s2_word.kind;
    s3_next.tag      = s2_word.tag;
    s3_next.err_many = s2_word.err_many;
    s3_next.err_few  = s2_word.err_few;
    s3_next.rect_hit = s2_word.rect_hit;
    s3_next.cross1   = crosses(s2_word.e1);
    s3_next.cross2   = crosses(s2_word.e2);
    s3_next.dp       = s2_word.cdx2 + s2_word.cdy2;
    s3_next.dr       = s2_word.rdx2 + s2_word.rdy2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (!stall) begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s2_word <= s2_next;
      s3_word <= s3_next;
    end
  end

endmodule

FILE: hdl/imrh_decide.sv
`timescale 1ns / 1ps
// Decision stage: crossing parity, current pick, search closure and result register.
// Depends on imrh_pkg and imrh_result_if.
module imrh_decide (
  input  logic                clk,
  input  logic                rst,
  input  logic                s3_valid,
  input  imrh_pkg::sum_word_t s3_word,
  output logic                stall,
  imrh_result_if.source       result
);
  import imrh_pkg::*;

  outcome_t         best_outcome;
  logic [TAG_W-1:0] best_tag;
  dist_t            best_dist;
  logic             closed;
  logic             parity;

  outcome_t         best_outcome_next;
  logic [TAG_W-1:0] best_tag_next;
  dist_t            best_dist_next;
  logic             closed_next;
  logic             parity_next;
  logic             take;
  logic             act;
  logic             par_run;
  logic             par_fin;

  assign stall   = s3_valid && s3_word.map_end && result.valid && !result.ready;
  assign take    = s3_valid && !stall;
  assign act     = !closed && s3_word.live;
  assign par_run = parity ^ s3_word.cross1;
  assign par_fin = par_run ^ s3_word.cross2;

  always_comb begin
    best_outcome_next = best_outcome;
    best_tag_next     = best_tag;
    best_dist_next    = best_dist;
    closed_next       = closed;
    parity_next       = parity;
    if (act) begin
      parity_next = par_run;
    end
    if (act && s3_word.ends) begin
      if (s3_word.err_many) begin
        best_outcome_next = OUT_MANY;
        best_tag_next     = '0;
        best_dist_next    = '0;
        closed_next       = 1'b1;
      end else if (s3_word.err_few) begin
        best_outcome_next = OUT_FEW;
        best_tag_next     = '0;
        best_dist_next    = '0;
        closed_next       = 1'b1;
      end else begin
        case (s3_word.kind) inside
          KIND_RECT, KIND_CIRCLE, KIND_POLYGON: begin
            if ((s3_word.kind == KIND_RECT && s3_word.rect_hit) ||
                (s3_word.kind == KIND_CIRCLE && s3_word.dp <= s3_word.dr) ||
                (s3_word.kind == KIND_POLYGON && par_fin)) begin
              best_outcome_next = OUT_HIT;
              best_tag_next     = s3_word.tag;
              closed_next       = 1'b1;
            end
          end
          KIND_DEFAULT: begin
            best_outcome_next = OUT_DEFAULT;
            best_tag_next     = s3_word.tag;
            best_dist_next    = '0;
          end
          default: begin
            if (best_outcome == OUT_NONE || s3_word.dp < best_dist) begin
              best_outcome_next = OUT_NEAREST;
              best_tag_next     = s3_word.tag;
              best_dist_next    = s3_word.dp;
            end
          end
        endcase
      end
    end
    if (s3_word.ends) begin
      parity_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_outcome <= OUT_NONE;
      best_tag     <= '0;
      best_dist    <= '0;
      closed       <= 1'b0;
      parity       <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (take && s3_word.map_end) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      if (take) begin
        parity <= parity_next;
        if (s3_word.map_end) begin
          best_outcome <= OUT_NONE;
          best_tag     <= '0;
          best_dist    <= '0;
          closed       <= 1'b0;
        end else begin
          best_outcome <= best_outcome_next;
          best_tag     <= best_tag_next;
          best_dist    <= best_dist_next;
          closed       <= closed_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && s3_word.map_end) begin
      result.outcome    <= best_outcome_next;
      result.chosen_tag <= best_tag_next;
    end
  end

endmodule

FILE: test/imrh_hit_checker.sv
`timescale 1ns / 1ps
// Result checker for the image map region hit test: tracks probe writes and vertex
// words, predicts one result word per map and compares it with the block's output.
// Depends on imrh_pkg and the channel interfaces in imrh_if.
module imrh_hit_checker #(
  parameter int MAX_VERT = imrh_pkg::MAX_VERT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [imrh_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [imrh_pkg::CFG_DATA_W-1:0]  cfg_data,
  imrh_item_if                             item,
  imrh_result_if                           result,
  output int                               fail_count,
  output int                               pending
);
  import imrh_pkg::*;

  typedef struct packed {
    outcome_t         outcome;
    logic [TAG_W-1:0] tag;
  } map_result_t;

  map_result_t      map_results_q[$];
  coord_t           px, py;
  coord_t           anchor_x, anchor_y, corner_x, corner_y, last_x, last_y;
  int               vert_count;
  logic             inside_odd;
  logic [TAG_W-1:0] pick_tag;
  longint           pick_dist;
  outcome_t         pick_outcome;
  logic             search_done;
  int               errs;

  task automatic report_mismatch(string what);
    $display("hit_check: %s at %0t ns", what, $time);
    errs++;
  endtask

  // Crossings test of one edge against the ray from the probe toward +x.
  function automatic logic edge_crosses(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
    longint dy, lhs;
    logic above0, above1, right0, right1;
    above0 = y0 >= py;
    above1 = y1 >= py;
    if (above0 == above1) return 1'b0;
    right0 = x0 >= px;
    right1 = x1 >= px;
    if (right0 == right1) return right0;
    dy  = longint'(y1) - longint'(y0);
    lhs = (longint'(x0) - longint'(px)) * dy
        - (longint'(y0) - longint'(py)) * (longint'(x1) - longint'(x0));
    if (dy > 0) return lhs >= 0;
    return lhs <= 0;
  endfunction

  function automatic longint dist2(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    longint dx, dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return dx * dx + dy * dy;
  endfunction

  function automatic void close_search(outcome_t code);
    pick_outcome = code;
    pick_tag     = '0;
    pick_dist    = 0;
    search_done  = 1'b1;
  endfunction

  function automatic void take_hit(logic [TAG_W-1:0] tag);
    pick_outcome = OUT_HIT;
    pick_tag     = tag;
    search_done  = 1'b1;
  endfunction

  function automatic void close_region(logic [KIND_W-1:0] kind, logic [TAG_W-1:0] tag);
    int     need;
    longint d;
    need = (kind == KIND_POLYGON) ? 3 : (kind == KIND_RECT || kind == KIND_CIRCLE) ? 2 : 1;
    if (vert_count > MAX_VERT) begin
      close_search(OUT_MANY);
      return;
    end
    if (vert_count < need) begin
      close_search(OUT_FEW);
      return;
    end
    case (kind)
      KIND_RECT: begin
        if (((px >= anchor_x && px <= corner_x) || (px >= corner_x && px <= anchor_x)) &&
            ((py >= anchor_y && py <= corner_y) || (py >= corner_y && py <= anchor_y)))
          take_hit(tag);
      end
      KIND_CIRCLE: begin
        if (dist2(anchor_x, anchor_y, px, py) <= dist2(anchor_x, anchor_y, corner_x, corner_y))
          take_hit(tag);
      end
      KIND_POLYGON: begin
        if (inside_odd) take_hit(tag);
      end
      KIND_DEFAULT: begin
        pick_outcome = OUT_DEFAULT;
        pick_tag     = tag;
        pick_dist    = 0;
      end
      default: begin
        d = dist2(px, py, anchor_x, anchor_y);
        if (pick_outcome == OUT_NONE || d < pick_dist) begin
          pick_outcome = OUT_NEAREST;
          pick_tag     = tag;
          pick_dist    = d;
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin : watch
    map_result_t       want;
    logic [KIND_W-1:0] kind;
    coord_t            vx, vy;
    logic              ends;
    if (rst) begin
      map_results_q.delete();
      px = '0; py = '0;
      anchor_x = '0; anchor_y = '0; corner_x = '0; corner_y = '0; last_x = '0; last_y = '0;
      vert_count   = 0;
      inside_odd   = 1'b0;
      pick_tag     = '0;
      pick_dist    = 0;
      pick_outcome = OUT_NONE;
      search_done  = 1'b0;
      errs         = 0;
    end else begin
      if (result.valid && result.ready) begin
        if (map_results_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result word outcome %0d tag %h",
                                    result.outcome, result.chosen_tag));
        end else begin
          want = map_results_q.pop_front();
          if (result.outcome !== want.outcome)
            report_mismatch($sformatf("outcome %0d, expected %0d",
                                      result.outcome, want.outcome));
          if (result.chosen_tag !== want.tag)
            report_mismatch($sformatf("chosen_tag %h, expected %h",
                                      result.chosen_tag, want.tag));
        end
      end
      if (cfg_write) begin
        if (cfg_index == REG_PROBE_X) px = cfg_data;
        else py = cfg_data;
      end
      if (item.valid && item.ready) begin
        kind = item.region_kind;
        vx   = item.vertex_x;
        vy   = item.vertex_y;
        ends = item.region_end || item.map_end;
        if (!search_done && kind <= KIND_POINT) begin
          if (vert_count == 0) begin
            anchor_x = vx;
            anchor_y = vy;
          end else begin
            inside_odd ^= edge_crosses(last_x, last_y, vx, vy);
            if (vert_count == 1) begin
              corner_x = vx;
              corner_y = vy;
            end
          end
          if (vert_count <= MAX_VERT) vert_count++;
          last_x = vx;
          last_y = vy;
          if (ends) begin
            inside_odd ^= edge_crosses(vx, vy, anchor_x, anchor_y);
            close_region(kind, item.target_tag);
          end
        end
        if (ends) begin
          vert_count = 0;
          inside_odd = 1'b0;
        end
        if (item.map_end) begin
          want.outcome = pick_outcome;
          want.tag     = pick_tag;
          map_results_q.push_back(want);
          pick_outcome = OUT_NONE;
          pick_tag     = '0;
          pick_dist    = 0;
          search_done  = 1'b0;
        end
      end
    end
    fail_count <= errs;
    pending    <= map_results_q.size();
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Top of the hit test bench: clock, reset, probe writes, vertex word stimulus and
// result back-pressure; the verdict comes from the failure count of imrh_hit_checker.
// Depends on imrh_pkg, imrh_if, image_map_region_hit_test_unit and imrh_hit_checker.
module tb;
  import imrh_pkg::*;

  localparam int                MAX_VERT     = MAX_VERT_DEF;
  localparam int                SETTLE       = 8;
  localparam int                PHASE_WORDS  = 140;
  localparam logic [KIND_W-1:0] KIND_SPARE6  = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE7  = 3'd7;
  localparam coord_t            COORD_MIN    = coord_t'(-32768);
  localparam coord_t            COORD_MAX    = coord_t'(32767);

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     fail_count;
  int                     pending;
  int                     send_idle_pct;
  int                     recv_stall_pct;
  int                     hold_len;
  int                     hold_left;
  int                     words_sent;
  coord_t                 px, py;

  imrh_item_if   item_ch ();
  imrh_result_if result_ch ();

  image_map_region_hit_test_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  imrh_hit_checker #(.MAX_VERT(MAX_VERT)) hit_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item       (item_ch),
    .result     (result_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      hold_left       <= 0;
    end else if (hold_len != 0) begin
      result_ch.ready <= 1'b0;
      hold_left       <= hold_len;
    end else if (hold_left != 0) begin
      result_ch.ready <= 1'b0;
      hold_left       <= hold_left - 1;
    end else begin
      result_ch.ready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

  task automatic send_word(logic [KIND_W-1:0] kind, coord_t x, coord_t y,
                           logic [TAG_W-1:0] tag, logic rend, logic mend);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.region_kind <= kind;
    item_ch.vertex_x    <= x;
    item_ch.vertex_y    <= y;
    item_ch.target_tag  <= tag;
    item_ch.region_end  <= rend;
    item_ch.map_end     <= mend;
    do @(posedge clk); while (!item_ch.ready);
    words_sent++;
  endtask

  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_probe(coord_t x, coord_t y);
    cfg_write <= 1'b1;
    cfg_index <= REG_PROBE_X;
    cfg_data  <= x;
    @(posedge clk);
    cfg_index <= REG_PROBE_Y;
    cfg_data  <= y;
    @(posedge clk);
    cfg_write <= 1'b0;
    px = x;
    py = y;
  endtask

  // Mostly close to the probe so that regions hit, sometimes anywhere, at the rails or at zero.
  function automatic coord_t near(coord_t c);
    int roll;
    roll = $urandom_range(99);
    if (roll < 75) return coord_t'(int'(c) + int'($urandom_range(40)) - 20);
    if (roll < 88) return coord_t'($urandom);
    case ($urandom_range(2))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      default: return '0;
    endcase
  endfunction

  task automatic send_region(logic [KIND_W-1:0] kind, int count, logic closes_map);
    logic [KIND_W-1:0] k;
    logic              rend, mend;
    int                i;
    for (i = 0; i < count; i++) begin
      if (i == count - 1) begin
        k    = kind;
        mend = closes_map;
        rend = closes_map ? logic'($urandom_range(1)) : 1'b1;
      end else begin
        if ($urandom_range(99) < 4)
          k = KIND_W'($urandom_range(int'(KIND_MARKER), int'(KIND_SPARE7)));
        else k = KIND_W'($urandom_range(int'(KIND_POINT)));
        rend = 1'b0;
        mend = 1'b0;
      end
      send_word(k, near(px), near(py), TAG_W'($urandom), rend, mend);
    end
  endtask

  task automatic send_map();
    int                regions, r, roll, count;
    logic [KIND_W-1:0] kind;
    regions = $urandom_range(1, 5);
    for (r = 0; r < regions; r++) begin
      roll = $urandom_range(999);
      if (roll < 3) begin
        kind  = KIND_POLYGON;
        count = $urandom_range(MAX_VERT, MAX_VERT + 12);
      end else if (roll < 220) begin
        kind  = KIND_RECT;
        count = ($urandom_range(9) == 0) ? $urandom_range(1, 4) : 2;
      end else if (roll < 400) begin
        kind  = KIND_CIRCLE;
        count = ($urandom_range(9) == 0) ? $urandom_range(1, 4) : 2;
      end else if (roll < 620) begin
        kind  = KIND_POLYGON;
        count = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
      end else if (roll < 700) begin
        kind  = KIND_DEFAULT;
        count = $urandom_range(1, 2);
      end else if (roll < 860) begin
        kind  = KIND_POINT;
        count = ($urandom_range(9) == 0) ? $urandom_range(2, 3) : 1;
      end else begin
        kind  = KIND_W'($urandom_range(int'(KIND_MARKER), int'(KIND_SPARE7)));
        count = $urandom_range(1, 3);
      end
      send_region(kind, count, r == regions - 1);
    end
  endtask

  task automatic send_directed();
    // map end without region end on a rectangle with swapped corners
    send_word(KIND_RECT, 10, 10, 16'h0101, 1'b0, 1'b0);
    send_word(KIND_RECT, -10, -10, 16'hFFFF, 1'b0, 1'b1);
    // circle spanning the whole plane
    send_word(KIND_CIRCLE, COORD_MAX, COORD_MAX, 16'h0202, 1'b0, 1'b0);
    send_word(KIND_CIRCLE, COORD_MIN, COORD_MIN, 16'h0001, 1'b1, 1'b1);
    // triangle around the probe
    send_word(KIND_POLYGON, -5, -5, 16'h0303, 1'b0, 1'b0);
    send_word(KIND_POLYGON, 5, -5, 16'h0303, 1'b0, 1'b0);
    send_word(KIND_POLYGON, 0, 5, 16'h8000, 1'b1, 1'b1);
    // edge crossing the probe row exactly at probe_x
    send_word(KIND_POLYGON, -2, -2, 16'h1234, 1'b0, 1'b0);
    send_word(KIND_POLYGON, 2, 2, 16'h1234, 1'b0, 1'b0);
    send_word(KIND_POLYGON, 5, -3, 16'h1234, 1'b1, 1'b1);
    // nearer point wins, a spare kind closes the map
    send_word(KIND_POINT, 1, 1, 16'h0008, 1'b1, 1'b0);
    send_word(KIND_POINT, 0, 1, 16'h0009, 1'b1, 1'b0);
    send_word(KIND_SPARE7, COORD_MAX, COORD_MIN, 16'h7777, 1'b1, 1'b1);
    // default replaces a point, a later point at zero distance does not
    send_word(KIND_POINT, 3, 3, 16'h0005, 1'b1, 1'b0);
    send_word(KIND_DEFAULT, 9, 9, 16'h0000, 1'b1, 1'b0);
    send_word(KIND_POINT, 0, 0, 16'h0007, 1'b1, 1'b1);
    // too few vertices closes the search, a later hit is ignored
    send_word(KIND_POLYGON, 1, 1, 16'h4444, 1'b0, 1'b0);
    send_word(KIND_POLYGON, 2, 2, 16'h4444, 1'b1, 1'b0);
    send_word(KIND_RECT, -1, -1, 16'h5555, 1'b0, 1'b0);
    send_word(KIND_RECT, 1, 1, 16'h5555, 1'b1, 1'b1);
    // spare kind drops pending vertices, marker closes an empty map
    send_word(KIND_POLYGON, -5, -5, 16'h6666, 1'b0, 1'b0);
    send_word(KIND_POLYGON, 5, -5, 16'h6666, 1'b0, 1'b0);
    send_word(KIND_SPARE6, 0, 0, 16'h6666, 1'b1, 1'b0);
    send_word(KIND_MARKER, 0, 0, 16'h6666, 1'b0, 1'b1);
  endtask

  initial begin
    int     ph, goal;
    coord_t nx, ny;
    rst                 <= 1'b1;
    cfg_write           <= 1'b0;
    cfg_index           <= REG_PROBE_X;
    cfg_data            <= '0;
    item_ch.valid       <= 1'b0;
    item_ch.region_kind <= KIND_RECT;
    item_ch.vertex_x    <= '0;
    item_ch.vertex_y    <= '0;
    item_ch.target_tag  <= '0;
    item_ch.region_end  <= 1'b0;
    item_ch.map_end     <= 1'b0;
    hold_len            <= 0;
    send_idle_pct  = 14;
    recv_stall_pct = 64;
    words_sent     = 0;
    px             = '0;
    py             = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_directed();
    wait_drained();

    for (ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        send_idle_pct  = 64;
        recv_stall_pct = 14;
      end else if (ph == 4) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      case (ph)
        0: begin nx = COORD_MIN; ny = COORD_MAX; end
        1: begin nx = COORD_MAX; ny = COORD_MIN; end
        2: begin nx = COORD_MAX; ny = COORD_MAX; end
        3: begin nx = COORD_MIN; ny = COORD_MIN; end
        default: begin nx = coord_t'($urandom); ny = coord_t'($urandom); end
      endcase
      write_probe(nx, ny);
      goal = words_sent + PHASE_WORDS;
      if (ph == 0) send_region(KIND_POLYGON, MAX_VERT + 1, 1'b1);
      if (ph == 4) begin
        hold_len <= 300;
        @(posedge clk);
        hold_len <= 0;
      end
      while (words_sent < goal) begin
        send_map();
        if (ph == 1 && words_sent >= goal - PHASE_WORDS / 2 && pending != 0) wait_drained();
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
